// File: design/pva_pkg.sv
// Shared constants, codes and types of the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

    // Pool size and the widths that follow from it.
    localparam int MAX_VOICES = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 5;

    // Input field widths.
    localparam int ACTION_W = 2;
    localparam int PITCH_W  = 24;
    localparam int LEVEL_W  = 15;
    localparam int STATUS_W = 3;
    localparam int POLICY_W = 2;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_STEAL_POLICY = 2'd0;

    // Steal policy bits.
    localparam int POL_OLDEST = 0;
    localparam int POL_EXPAND = 1;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PLAY   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESIZE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_FREE         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STOLE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXPAND       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_SOUNDING = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RESIZED      = 3'd6;

    // Operation broadcast to every cell of the free stack.
    typedef enum logic [1:0] {
        FREE_HOLD,
        FREE_PUSH,
        FREE_POP
    } free_op_t;

    // Search broadcast to the sounding list: compare key against live cells.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] key;
        logic [CNT_W-1:0]  count;
    } sound_match_t;

    // Update broadcast to the sounding list.
    typedef struct packed {
        logic              append_en;
        logic              remove_en;
        logic [SLOT_W-1:0] tail_pos;
        logic [SLOT_W-1:0] app_id;
    } sound_ctl_t;

    // Lowest slot id whose existence bit is clear.
    function automatic logic [SLOT_W-1:0] lowest_unused(input logic [MAX_VOICES-1:0] exists);
        logic [SLOT_W-1:0] id;
        id = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--) begin
            if (!exists[i])
            begin
                id = SLOT_W'(i);
            end
        end
        return id;
    endfunction

endpackage

`default_nettype wire

// File: design/pva_free_cell.sv
// One cell of the free stack; the top of the stack is cell zero.
`default_nettype none

module pva_free_cell
    import pva_pkg::*;
(
    input  wire logic              clk,
    input  wire free_op_t          op,
    input  wire logic [SLOT_W-1:0] left_id,
    input  wire logic [SLOT_W-1:0] right_id,
    output logic      [SLOT_W-1:0] id
);

    logic [SLOT_W-1:0] id_reg;
    logic [SLOT_W-1:0] id_next;

    // A push moves every entry one cell deeper; a pop moves it one cell up.
    always_comb
    begin
        unique case (op)
            FREE_PUSH: id_next = left_id;
            FREE_POP:  id_next = right_id;
            default:   id_next = id_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

// File: design/pva_sound_cell.sv
// One cell of the sounding list, which is held oldest first from cell zero.
`default_nettype none

module pva_sound_cell
    import pva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [SLOT_W-1:0] idx,
    input  wire sound_match_t      mtch,
    input  wire sound_ctl_t        ctl,
    input  wire logic              hit_in,
    input  wire logic [SLOT_W-1:0] right_id,
    output logic                   hit_out,
    output logic      [SLOT_W-1:0] id
);

    logic [SLOT_W-1:0] id_reg;
    logic [SLOT_W-1:0] id_next;
    logic              live;
    logic              match;

    // The hit chain marks the cell that holds the removed entry and every cell after it.
    assign live    = {1'b0, idx} < mtch.count;
    assign match   = mtch.en && live && (id_reg == mtch.key);
    assign hit_out = hit_in | match;

    // Appending writes the tail position; removal pulls in the right neighbour.
    always_comb
    begin
        priority if (ctl.append_en && (idx == ctl.tail_pos))
        begin
            id_next = ctl.app_id;
        end
        else if (ctl.remove_en && hit_out)
        begin
            id_next = right_id;
        end
        else
        begin
            id_next = id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

// File: design/polyphonic_voice_allocator_top.sv
// Top level of the polyphonic voice allocator: control, counters and the cell rows.
//
// Voice allocator for up to 16 slots. Each input beat is latched in the idle
// state and executed in the exec state, where a step that ends an item waits
// until the output register is free. A resize adds or removes one slot per
// cycle until the total matches the request. The result is held in an output
// register, so the next input beat is taken while a result still waits. Idle
// slots sit in a row of shifting free-stack cells and sounding slots in a row
// of cells kept oldest first; releasing a slot closes its gap by a shift along
// the row. steal_policy sits at byte address 0 of the configuration port.
`default_nettype none

module polyphonic_voice_allocator_top
    import pva_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    // Input channel.
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [SLOT_W-1:0]   done_slot,
    input  wire logic [PITCH_W-1:0]  pitch,
    input  wire logic [LEVEL_W-1:0]  note_level,
    input  wire logic [CNT_W-1:0]    requested_voices,
    // Output channel.
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [STATUS_W-1:0] status,
    output logic      [SLOT_W-1:0]   voice_slot,
    output logic      [PITCH_W-1:0]  out_pitch,
    output logic      [LEVEL_W-1:0]  out_level,
    output logic      [CNT_W-1:0]    voices_total,
    output logic      [CNT_W-1:0]    voices_sounding
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg;
    logic [POLICY_W-1:0]     policy_reg;
    logic [CNT_W-1:0]        fc_reg;
    logic [CNT_W-1:0]        fc_next;
    logic [CNT_W-1:0]        sc_reg;
    logic [CNT_W-1:0]        sc_next;
    logic [MAX_VOICES-1:0]   exists_reg;
    logic [MAX_VOICES-1:0]   exists_next;

    // Latched input beat.
    logic [ACTION_W-1:0]     action_reg;
    logic [SLOT_W-1:0]       done_reg;
    logic [PITCH_W-1:0]      pitch_reg;
    logic [LEVEL_W-1:0]      level_reg;
    logic [CNT_W-1:0]        req_reg;
    logic [CNT_W-1:0]        req_sat;

    // Output register.
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PITCH_W-1:0]      opitch_reg;
    logic [LEVEL_W-1:0]      olevel_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        sounding_reg;

    // Cell rows.
    logic [SLOT_W-1:0]       fs_ids [MAX_VOICES];
    logic [SLOT_W-1:0]       so_ids [MAX_VOICES];
    logic                    hit_w  [MAX_VOICES+1];
    free_op_t                fop_raw;
    free_op_t                fop;
    logic [SLOT_W-1:0]       push_id;
    sound_match_t            smatch;
    sound_ctl_t              sctl_raw;
    sound_ctl_t              sctl;

    // Execution results.
    logic [CNT_W-1:0]        total;
    logic                    steal_first;
    logic                    any_hit;
    logic [SLOT_W-1:0]       lowest_id;
    logic [SLOT_W-1:0]       newest_id;
    logic [CNT_W-1:0]        sc_minus1;
    logic                    item_end;
    logic [STATUS_W-1:0]     st;
    logic [SLOT_W-1:0]       slot;
    logic                    granted;
    logic                    out_free;
    logic                    commit;
    logic                    in_fire;
    logic                    cfg_write;

    assign total     = fc_reg + sc_reg;
    assign sc_minus1 = sc_reg - CNT_W'(1);
    assign lowest_id = lowest_unused(exists_reg);
    assign newest_id = so_ids[sc_minus1[SLOT_W-1:0]];
    assign req_sat   = (requested_voices > CNT_W'(MAX_VOICES)) ? CNT_W'(MAX_VOICES)
                                                               : requested_voices;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign commit    = (state_reg == S_EXEC) && (!item_end || out_free);

    // Configuration port: always ready, single register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_STEAL_POLICY);
    assign prdata    = (paddr == REG_STEAL_POLICY) ? PDATA_W'(policy_reg) : '0;

    // Search for a released slot; a steal removes the oldest entry instead.
    assign steal_first = (action_reg == ACT_PLAY) && (fc_reg == '0)
                         && policy_reg[POL_OLDEST] && (sc_reg != '0);
    assign smatch.en    = (action_reg == ACT_DONE);
    assign smatch.key   = done_reg;
    assign smatch.count = sc_reg;
    assign hit_w[0]     = steal_first;
    assign any_hit      = hit_w[MAX_VOICES];

    // Decide the update for the latched beat.
    always_comb
    begin
        fop_raw     = FREE_HOLD;
        push_id     = '0;
        sctl_raw    = '0;
        fc_next     = fc_reg;
        sc_next     = sc_reg;
        exists_next = exists_reg;
        st          = ST_REFUSED;
        slot        = '0;
        granted     = 1'b0;
        item_end    = 1'b1;
        unique case (action_reg)
            ACT_PLAY:
            begin
                if (fc_reg != '0)
                begin
                    // Take the top free slot and append it as the newest voice.
                    slot               = fs_ids[0];
                    fop_raw            = FREE_POP;
                    fc_next            = fc_reg - CNT_W'(1);
                    sctl_raw.append_en = 1'b1;
                    sctl_raw.tail_pos  = sc_reg[SLOT_W-1:0];
                    sctl_raw.app_id    = slot;
                    sc_next            = sc_reg + CNT_W'(1);
                    st                 = ST_FREE;
                    granted            = 1'b1;
                end
                else if (steal_first)
                begin
                    // Rotate the oldest voice round to the newest position.
                    slot               = so_ids[0];
                    sctl_raw.remove_en = 1'b1;
                    sctl_raw.append_en = 1'b1;
                    sctl_raw.tail_pos  = sc_minus1[SLOT_W-1:0];
                    sctl_raw.app_id    = slot;
                    st                 = ST_STOLE;
                    granted            = 1'b1;
                end
                else if (policy_reg[POL_EXPAND] && (total < CNT_W'(MAX_VOICES)))
                begin
                    // Create the lowest unused slot and grant it at once.
                    slot                   = lowest_id;
                    exists_next[lowest_id] = 1'b1;
                    sctl_raw.append_en     = 1'b1;
                    sctl_raw.tail_pos      = sc_reg[SLOT_W-1:0];
                    sctl_raw.app_id        = slot;
                    sc_next                = sc_reg + CNT_W'(1);
                    st                     = ST_EXPAND;
                    granted                = 1'b1;
                end
            end
            ACT_DONE:
            begin
                if (any_hit)
                begin
                    sctl_raw.remove_en = 1'b1;
                    sc_next            = sc_minus1;
                    fop_raw            = FREE_PUSH;
                    push_id            = done_reg;
                    fc_next            = fc_reg + CNT_W'(1);
                    st                 = ST_RELEASED;
                    slot               = done_reg;
                end
                else
                begin
                    st = ST_NOT_SOUNDING;
                end
            end
            ACT_RESIZE:
            begin
                st = ST_RESIZED;
                if (total < req_reg)
                begin
                    // Grow by one slot this cycle.
                    item_end               = 1'b0;
                    fop_raw                = FREE_PUSH;
                    push_id                = lowest_id;
                    exists_next[lowest_id] = 1'b1;
                    fc_next                = fc_reg + CNT_W'(1);
                end
                else if (total > req_reg)
                begin
                    // Shrink by one slot: free slots first, then the newest voice.
                    item_end = 1'b0;
                    if (fc_reg != '0)
                    begin
                        fop_raw                = FREE_POP;
                        exists_next[fs_ids[0]] = 1'b0;
                        fc_next                = fc_reg - CNT_W'(1);
                    end
                    else
                    begin
                        exists_next[newest_id] = 1'b0;
                        sc_next                = sc_minus1;
                    end
                end
            end
            default:
            begin
                st = ST_REFUSED;
            end
        endcase
    end

    // Cells change only when the step actually commits.
    always_comb
    begin
        fop            = commit ? fop_raw : FREE_HOLD;
        sctl           = sctl_raw;
        sctl.append_en = sctl_raw.append_en && commit;
        sctl.remove_en = sctl_raw.remove_en && commit;
    end

    // Rows of cells.
    for (genvar j = 0; j < MAX_VOICES; j++)
    begin : g_cells
        logic [SLOT_W-1:0] fs_left;
        logic [SLOT_W-1:0] fs_right;
        logic [SLOT_W-1:0] so_right;

        if (j == 0)
        begin : g_first
            assign fs_left = push_id;
        end
        else
        begin : g_inner_l
            assign fs_left = fs_ids[j-1];
        end

        if (j == MAX_VOICES - 1)
        begin : g_last
            assign fs_right = '0;
            assign so_right = '0;
        end
        else
        begin : g_inner_r
            assign fs_right = fs_ids[j+1];
            assign so_right = so_ids[j+1];
        end

        pva_free_cell u_free (
            .clk      (clk),
            .op       (fop),
            .left_id  (fs_left),
            .right_id (fs_right),
            .id       (fs_ids[j])
        );

        pva_sound_cell u_sound (
            .clk      (clk),
            .idx      (SLOT_W'(j)),
            .mtch     (smatch),
            .ctl      (sctl),
            .hit_in   (hit_w[j]),
            .right_id (so_right),
            .hit_out  (hit_w[j+1]),
            .id       (so_ids[j])
        );
    end

    // Control state, counters, latched beat and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= '0;
            fc_reg        <= '0;
            sc_reg        <= '0;
            exists_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                policy_reg <= pwdata[POLICY_W-1:0];
            end

            // The output register refills when an item ends and empties when its beat is taken.
            if (commit && item_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        action_reg <= action;
                        done_reg   <= done_slot;
                        pitch_reg  <= pitch;
                        level_reg  <= note_level;
                        req_reg    <= req_sat;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        fc_reg     <= fc_next;
                        sc_reg     <= sc_next;
                        exists_reg <= exists_next;
                        if (item_end)
                        begin
                            status_reg    <= st;
                            slot_reg      <= slot;
                            opitch_reg    <= granted ? pitch_reg : '0;
                            olevel_reg    <= granted ? level_reg : '0;
                            total_reg     <= fc_next + sc_next;
                            sounding_reg  <= sc_next;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign voice_slot      = slot_reg;
    assign out_pitch       = opitch_reg;
    assign out_level       = olevel_reg;
    assign voices_total    = total_reg;
    assign voices_sounding = sounding_reg;

endmodule

`default_nettype wire

// File: test/polyphonic_voice_allocator_top_tb.sv
// Self-checking testbench for the polyphonic voice allocator: stimulus, prediction and checks.
`default_nettype none

module polyphonic_voice_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    // The action code that the block leaves undefined.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // The tail after the last result covers the longest resize.
    localparam int TAIL_CYCLES = 24;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LONG_HOLD   = 80;

    // One note event as presented on the input channel.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   done_slot;
        logic [PITCH_W-1:0]  pitch;
        logic [LEVEL_W-1:0]  level;
        logic [CNT_W-1:0]    requested;
    } note_event_t;

    // One allocation outcome as presented on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PITCH_W-1:0]  pitch;
        logic [LEVEL_W-1:0]  level;
        logic [CNT_W-1:0]    total;
        logic [CNT_W-1:0]    sounding;
    } voice_outcome_t;

    // Shadow voice pool: predicts each outcome and checks the block's results in order.
    class voice_pool_scoreboard;
        logic [SLOT_W-1:0]     idle_stack [MAX_VOICES];
        logic [SLOT_W-1:0]     live_order [MAX_VOICES];
        int                    idle_count;
        int                    live_count;
        logic [MAX_VOICES-1:0] slot_in_use;
        logic [POLICY_W-1:0]   policy;
        voice_outcome_t        outcomes [$];
        int                    mismatches;
        int                    accepted;
        int                    status_seen [8];

        function new();
            idle_count  = 0;
            live_count  = 0;
            slot_in_use = '0;
            policy      = '0;
            mismatches  = 0;
            accepted    = 0;
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        function void set_policy(input logic [POLICY_W-1:0] value);
            policy = value;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        // A slot that is sounding now, or any slot id when none is.
        function logic [SLOT_W-1:0] any_live_slot();
            if (live_count == 0)
            begin
                return SLOT_W'($urandom_range(MAX_VOICES - 1));
            end
            return live_order[$urandom_range(live_count - 1)];
        endfunction

        // Push the lowest unused slot id onto the idle stack, if the pool has room.
        function bit grow_one();
            if (idle_count + live_count >= MAX_VOICES)
            begin
                return 1'b0;
            end
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                if (!slot_in_use[i])
                begin
                    slot_in_use[i]         = 1'b1;
                    idle_stack[idle_count] = SLOT_W'(i);
                    idle_count++;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Close the gap left in the sounding list at position pos.
        function void remove_live_at(input int pos);
            for (int i = pos; i + 1 < live_count; i++)
            begin
                live_order[i] = live_order[i + 1];
            end
            live_count--;
        endfunction

        function void append_live(input logic [SLOT_W-1:0] id);
            if (live_count < MAX_VOICES)
            begin
                live_order[live_count] = id;
                live_count++;
            end
        endfunction

        // Work out the outcome of an accepted note event and queue it.
        function void note_event(input note_event_t ev);
            voice_outcome_t    want;
            logic [SLOT_W-1:0] id;
            bit                granted;
            int                pos;
            int                target;

            want        = '0;
            want.status = ST_REFUSED;
            granted     = 1'b0;
            accepted++;
            case (ev.action)
                ACT_PLAY:
                begin
                    if (idle_count == 0)
                    begin
                        // Nothing idle: the steal policy decides.
                        if (policy[POL_OLDEST] && live_count > 0)
                        begin
                            id = live_order[0];
                            remove_live_at(0);
                            append_live(id);
                            want.status = ST_STOLE;
                            want.slot   = id;
                            granted     = 1'b1;
                        end
                        else if (policy[POL_EXPAND] && grow_one())
                        begin
                            want.status = ST_EXPAND;
                        end
                    end
                    else
                    begin
                        want.status = ST_FREE;
                    end
                    if (!granted && want.status != ST_REFUSED)
                    begin
                        idle_count--;
                        id = idle_stack[idle_count];
                        append_live(id);
                        want.slot = id;
                        granted   = 1'b1;
                    end
                end
                ACT_DONE:
                begin
                    want.status = ST_NOT_SOUNDING;
                    pos         = -1;
                    for (int i = 0; i < live_count; i++)
                    begin
                        if (pos < 0 && live_order[i] == ev.done_slot)
                        begin
                            pos = i;
                        end
                    end
                    if (pos >= 0)
                    begin
                        remove_live_at(pos);
                        if (idle_count < MAX_VOICES)
                        begin
                            idle_stack[idle_count] = ev.done_slot;
                            idle_count++;
                        end
                        want.status = ST_RELEASED;
                        want.slot   = ev.done_slot;
                    end
                end
                ACT_RESIZE:
                begin
                    target = (ev.requested > MAX_VOICES) ? MAX_VOICES : int'(ev.requested);
                    while (idle_count + live_count < target)
                    begin
                        void'(grow_one());
                    end
                    // Shrinking takes idle slots first, then the newest sounding ones.
                    while (idle_count + live_count > target)
                    begin
                        if (idle_count > 0)
                        begin
                            idle_count--;
                            id = idle_stack[idle_count];
                        end
                        else
                        begin
                            live_count--;
                            id = live_order[live_count];
                        end
                        slot_in_use[id] = 1'b0;
                    end
                    want.status = ST_RESIZED;
                end
                default:
                begin
                    want.status = ST_REFUSED;
                end
            endcase
            want.pitch    = granted ? ev.pitch : '0;
            want.level    = granted ? ev.level : '0;
            want.total    = CNT_W'(idle_count + live_count);
            want.sounding = CNT_W'(live_count);
            outcomes.push_back(want);
        endfunction

        function void compare_field(input string what, input longint unsigned want,
                                    input longint unsigned got);
            if (want != got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                mismatches++;
            end
        endfunction

        // Compare a result beat with the oldest outcome still waiting.
        function void check_outcome(input voice_outcome_t got);
            voice_outcome_t want;

            if (outcomes.size() == 0)
            begin
                $display("%0t ns: result with nothing waiting, expected none, actual status %0d",
                         $time, got.status);
                mismatches++;
                return;
            end
            want = outcomes.pop_front();
            status_seen[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("voice_slot", want.slot, got.slot);
            compare_field("out_pitch", want.pitch, got.pitch);
            compare_field("out_level", want.level, got.level);
            compare_field("voices_total", want.total, got.total);
            compare_field("voices_sounding", want.sounding, got.sounding);
        endfunction
    endclass

    // Clock, reset and the block's ports.
    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                psel             = 1'b0;
    logic                penable          = 1'b0;
    logic                pwrite           = 1'b0;
    logic [PADDR_W-1:0]  paddr            = '0;
    logic [PDATA_W-1:0]  pwdata           = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action           = '0;
    logic [SLOT_W-1:0]   done_slot        = '0;
    logic [PITCH_W-1:0]  pitch            = '0;
    logic [LEVEL_W-1:0]  note_level       = '0;
    logic [CNT_W-1:0]    requested_voices = '0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   voice_slot;
    logic [PITCH_W-1:0]  out_pitch;
    logic [LEVEL_W-1:0]  out_level;
    logic [CNT_W-1:0]    voices_total;
    logic [CNT_W-1:0]    voices_sounding;

    voice_pool_scoreboard sb;
    int                   hold_requests = 0;

    polyphonic_voice_allocator_top dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(3, 1);
        end
        if (r < 97)
        begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(40, 20);
    endfunction

    function automatic note_event_t make_event(input logic [ACTION_W-1:0] act,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [PITCH_W-1:0] freq,
                                               input logic [LEVEL_W-1:0] amp,
                                               input logic [CNT_W-1:0] count);
        note_event_t ev;
        ev.action    = act;
        ev.done_slot = slot;
        ev.pitch     = freq;
        ev.level     = amp;
        ev.requested = count;
        return ev;
    endfunction

    // Random note event; releases mostly name a slot that is sounding.
    function automatic note_event_t random_event(input int play_pct);
        note_event_t ev;
        int          r;

        ev.action    = ACT_PLAY;
        ev.done_slot = SLOT_W'($urandom);
        ev.pitch     = PITCH_W'($urandom);
        ev.level     = LEVEL_W'($urandom);
        ev.requested = CNT_W'($urandom);
        r = $urandom_range(99);
        if (r >= play_pct)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                ev.action = ACT_DONE;
                if ($urandom_range(99) < 80)
                begin
                    ev.done_slot = sb.any_live_slot();
                end
            end
            else if (r < 88)
            begin
                ev.action = ACT_RESIZE;
                if ($urandom_range(99) < 85)
                begin
                    ev.requested = CNT_W'($urandom_range(MAX_VOICES));
                end
            end
            else
            begin
                ev.action = ACT_UNUSED;
            end
        end
        return ev;
    endfunction

    // Offer one beat after an optional gap and wait until it is taken.
    task automatic send_event(input note_event_t ev, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {action, done_slot, pitch, note_level, requested_voices} <= ev;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering and wait until every outcome has come back and the block is quiet.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        // Wait on the clock first, so that the last accepted beat has been noted.
        @(posedge clk);
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, sb.pending());
            sb.mismatches++;
            sb.outcomes.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write the steal policy over the configuration port and read it back.
    task automatic write_policy(input logic [POLICY_W-1:0] value);
        logic [PDATA_W-1:0] readback;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_STEAL_POLICY;
        pwdata  <= {$urandom} & ~PDATA_W'(3) | PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_policy(value);
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.compare_field("steal_policy readback", value, readback[POLICY_W-1:0]);
    endtask

    // One phase of random traffic under a single steal policy.
    task automatic run_phase(input logic [POLICY_W-1:0] policy, input int count,
                             input int play_pct, input bit busy, input bit squeeze);
        settle();
        write_policy(policy);
        if (squeeze)
        begin
            hold_requests <= hold_requests + 1;
        end
        repeat (count)
        begin
            send_event(random_event(play_pct), (busy || squeeze) ? 0 : pick_gap());
        end
    endtask

    // Note every accepted beat on both channels; input first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_event({action, done_slot, pitch, note_level, requested_voices});
            end
            if (out_valid && out_ready)
            begin
                sb.check_outcome({status, voice_slot, out_pitch, out_level,
                                  voices_total, voices_sounding});
            end
        end
    end

    // Result side: random stalls and ready stretches, plus the long hold on request.
    initial
    begin : receiver
        int run_left;
        int holds_served;
        int r;

        run_left     = 0;
        holds_served = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                out_ready <= 1'b0;
                run_left  = LONG_HOLD;
            end
            else if (run_left == 0)
            begin
                r = $urandom_range(99);
                if (r < 30)
                begin
                    out_ready <= 1'b0;
                    run_left  = pick_gap() + 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    run_left  = (r < 36) ? $urandom_range(100, 40) : $urandom_range(8, 1);
                end
            end
            run_left--;
        end
    end

    initial
    begin : watchdog
        #6ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool, stray release, unknown action, oversized resize, extremes.
        write_policy(2'd0);
        send_event(make_event(ACT_PLAY, '0, '1, '1, '0), pick_gap());
        send_event(make_event(ACT_DONE, '1, '0, '0, '0), pick_gap());
        send_event(make_event(ACT_UNUSED, '1, '1, '1, '1), pick_gap());
        send_event(make_event(ACT_RESIZE, '0, '0, '0, '1), pick_gap());
        send_event(make_event(ACT_PLAY, '0, '0, '0, '0), pick_gap());
        send_event(make_event(ACT_PLAY, '0, '1, '1, '0), pick_gap());
        send_event(make_event(ACT_DONE, 4'd15, '0, '0, '0), pick_gap());
        send_event(make_event(ACT_DONE, 4'd15, '0, '0, '0), pick_gap());
        send_event(make_event(ACT_RESIZE, '0, '0, '0, 5'd1), pick_gap());
        send_event(make_event(ACT_RESIZE, '0, '0, '0, 5'd0), pick_gap());

        // Nothing to steal, so expand; then steal the oldest and release the head.
        settle();
        write_policy(2'd3);
        repeat (3)
        begin
            send_event(make_event(ACT_PLAY, '0, PITCH_W'($urandom), LEVEL_W'($urandom), '0),
                       pick_gap());
        end
        send_event(make_event(ACT_DONE, 4'd0, '0, '0, '0), pick_gap());

        // Exact maximum through a resize under expand-only policy.
        settle();
        write_policy(2'd2);
        send_event(make_event(ACT_RESIZE, '0, '0, '0, 5'd16), pick_gap());

        // Random traffic over the policy settings; one phase squeezes the output.
        run_phase(2'd1, 90, 55, 1'b0, 1'b0);
        run_phase(2'd2, 90, 70, 1'b0, 1'b0);
        run_phase(2'd0, 80, 60, 1'b1, 1'b0);
        run_phase(2'd3, 30, 60, 1'b1, 1'b1);
        run_phase(2'd3, 90, 50, 1'b0, 1'b0);
        run_phase(2'd2, 100, 85, 1'b0, 1'b0);
        run_phase(2'd0, 90, 45, 1'b0, 1'b0);
        run_phase(2'd1, 90, 65, 1'b1, 1'b0);
        run_phase(2'd3, 90, 55, 1'b0, 1'b0);
        settle();

        $display("Run covered %0d note events under all four steal policies, with a long output hold.",
                 sb.accepted);
        $display("Outcomes: %0d free, %0d stolen, %0d expanded, %0d refused, %0d released, %0d stray, %0d resized.",
                 sb.status_seen[ST_FREE], sb.status_seen[ST_STOLE], sb.status_seen[ST_EXPAND],
                 sb.status_seen[ST_REFUSED], sb.status_seen[ST_RELEASED],
                 sb.status_seen[ST_NOT_SOUNDING], sb.status_seen[ST_RESIZED]);
        if (sb.mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
